// ----- hw/rtl/bme_pkg.sv -----
// Shared constants and controller/datapath interface types for the monomial expander.
package bme_pkg;

   localparam int MAX_DEGREE = 6;
   localparam int ROWS       = MAX_DEGREE + 1;
   localparam int DEG_W      = 3;
   localparam int IDX_W      = 3;
   localparam int POW_W      = 3;
   localparam int K_W        = 5;
   localparam int IN_W       = 16;
   localparam int TERM_W     = 32;
   localparam int PROD_W     = TERM_W + IN_W;
   localparam int FRAC_SHIFT = 12;
   localparam int Q_W        = PROD_W - FRAC_SHIFT;

   localparam logic [DEG_W-1:0]  DEGREE_RESET = 3'd2;
   localparam logic [DEG_W-1:0]  DEGREE_TOP   = DEG_W'(MAX_DEGREE);
   localparam logic [TERM_W-1:0] ONE_Q24      = 32'h0100_0000;
   localparam logic [PROD_W-1:0] ROUND_HALF   = 48'd2048;

   // Commands from controller to datapath
   typedef struct packed {
      logic             load_point;
      logic             load_one;
      logic             mul;
      logic             rnd;
      logic             use_y;
      logic [IDX_W-1:0] row_idx;
      logic [K_W-1:0]   term_index;
      logic [POW_W-1:0] x_power;
      logic [POW_W-1:0] y_power;
      logic             last;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

// ----- hw/rtl/bme_ctrl.sv -----
// Sequencer for the monomial expander: row/term counters and command generation.
module bme_ctrl
   import bme_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic             csr_wr_en,
   input  logic [DEG_W-1:0] csr_wr_data,
   input  status_type       status,
   output cmd_type          cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ONE,
      ST_MUL,
      ST_RND
   } state_type;

   state_type        state_ff, state_in;
   logic [DEG_W-1:0] deg_ff, deg_in;
   logic [DEG_W-1:0] dmax_ff, dmax_in;
   logic [IDX_W-1:0] n_ff, n_in;
   logic [IDX_W-1:0] t_ff, t_in;
   logic [K_W-1:0]   k_ff, k_in;
   logic [DEG_W-1:0] deg_eff;
   logic             accept;
   logic             row_end;
   logic             last_term;

   assign deg_eff    = (deg_ff > DEGREE_TOP) ? DEGREE_TOP : deg_ff;
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign row_end    = (t_ff == n_ff);
   assign last_term  = row_end && (n_ff == dmax_ff);

   // Command decode
   always_comb begin
      cmd            = '0;
      cmd.load_point = accept;
      cmd.row_idx    = t_ff;
      cmd.use_y      = row_end;
      cmd.term_index = k_ff;
      cmd.x_power    = POW_W'(n_ff - t_ff);
      cmd.y_power    = POW_W'(t_ff);
      unique case (state_ff)
         ST_IDLE: ;
         ST_ONE: begin
            cmd.load_one   = status.out_free;
            cmd.term_index = '0;
            cmd.x_power    = '0;
            cmd.y_power    = '0;
            cmd.last       = (dmax_ff == '0);
         end
         ST_MUL: cmd.mul = 1'b1;
         ST_RND: begin
            cmd.rnd  = status.out_free;
            cmd.last = last_term;
         end
         default: ;
      endcase
   end

   // Next state and counters
   always_comb begin
      state_in = state_ff;
      deg_in   = csr_wr_en ? csr_wr_data : deg_ff;
      dmax_in  = dmax_ff;
      n_in     = n_ff;
      t_in     = t_ff;
      k_in     = k_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               dmax_in  = deg_eff;
               state_in = ST_ONE;
            end
         end
         ST_ONE: begin
            if (status.out_free) begin
               n_in     = IDX_W'(1);
               t_in     = '0;
               k_in     = K_W'(1);
               state_in = (dmax_ff == '0) ? ST_IDLE : ST_MUL;
            end
         end
         ST_MUL: state_in = ST_RND;
         ST_RND: begin
            if (status.out_free) begin
               k_in = k_ff + K_W'(1);
               if (last_term) begin
                  state_in = ST_IDLE;
               end else if (row_end) begin
                  n_in     = n_ff + IDX_W'(1);
                  t_in     = '0;
                  state_in = ST_MUL;
               end else begin
                  t_in     = t_ff + IDX_W'(1);
                  state_in = ST_MUL;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         deg_ff   <= DEGREE_RESET;
         dmax_ff  <= '0;
         n_ff     <= '0;
         t_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         deg_ff   <= deg_in;
         dmax_ff  <= dmax_in;
         n_ff     <= n_in;
         t_ff     <= t_in;
         k_ff     <= k_in;
      end
   end

endmodule

// ----- hw/rtl/bme_datapath.sv -----
// Datapath: point registers, degree row store, shared multiplier, rounding and output register.
module bme_datapath
   import bme_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [31:0]       req_tdata,
   input  cmd_type           cmd,
   output status_type        status,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [47:0]       rsp_tdata,
   output logic              rsp_tuser,
   output logic              rsp_tlast
);

   logic signed [IN_W-1:0]   x_ff, y_ff;
   logic signed [TERM_W-1:0] row_ff [ROWS];
   logic                     rsat_ff [ROWS];
   logic signed [TERM_W-1:0] hold_ff;
   logic                     hold_sat_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic                     psat_ff;

   logic                     valid_ff, valid_in;
   logic [TERM_W-1:0]        val_ff;
   logic [K_W-1:0]           idx_ff;
   logic [POW_W-1:0]         xp_ff, yp_ff;
   logic                     sat_ff, last_ff;

   logic signed [TERM_W-1:0] operand;
   logic signed [IN_W-1:0]   factor;
   logic                     op_sat;
   logic signed [PROD_W-1:0] rsum;
   logic signed [Q_W-1:0]    q;
   logic                     clip;
   logic [TERM_W-1:0]        rounded;

   assign status.out_free = !valid_ff || rsp_tready;

   // Operand select for the shared multiplier
   assign operand = cmd.use_y ? hold_ff : row_ff[cmd.row_idx];
   assign op_sat  = cmd.use_y ? hold_sat_ff : rsat_ff[cmd.row_idx];
   assign factor  = cmd.use_y ? y_ff : x_ff;

   // Round half up, drop 12 fraction bits, clamp to 32 bits
   assign rsum = prod_ff + $signed(ROUND_HALF);
   assign q    = rsum[PROD_W-1:FRAC_SHIFT];
   assign clip = (q[Q_W-1:TERM_W-1] != '0) && (q[Q_W-1:TERM_W-1] != '1);
   always_comb begin
      if (!clip)
         rounded = q[TERM_W-1:0];
      else if (q[Q_W-1])
         rounded = 32'h8000_0000;
      else
         rounded = 32'h7FFF_FFFF;
   end

   // Point, row store and product registers
   always_ff @(posedge clock) begin
      if (cmd.load_point) begin
         x_ff <= req_tdata[15:0];
         y_ff <= req_tdata[31:16];
      end
      if (cmd.load_one) begin
         row_ff[0]  <= ONE_Q24;
         rsat_ff[0] <= 1'b0;
      end
      if (cmd.mul) begin
         prod_ff <= operand * factor;
         psat_ff <= op_sat;
         if (!cmd.use_y) begin
            hold_ff     <= row_ff[cmd.row_idx];
            hold_sat_ff <= rsat_ff[cmd.row_idx];
         end
      end
      if (cmd.rnd) begin
         row_ff[cmd.row_idx]  <= rounded;
         rsat_ff[cmd.row_idx] <= psat_ff | clip;
      end
   end

   // Output register payload
   always_ff @(posedge clock) begin
      if (cmd.load_one) begin
         val_ff <= ONE_Q24;
         sat_ff <= 1'b0;
      end else if (cmd.rnd) begin
         val_ff <= rounded;
         sat_ff <= psat_ff | clip;
      end
      if (cmd.load_one || cmd.rnd) begin
         idx_ff  <= cmd.term_index;
         xp_ff   <= cmd.x_power;
         yp_ff   <= cmd.y_power;
         last_ff <= cmd.last;
      end
   end

   // Output valid
   always_comb begin
      valid_in = valid_ff;
      if (cmd.load_one || cmd.rnd)
         valid_in = 1'b1;
      else if (rsp_tready)
         valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else
         valid_ff <= valid_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {5'b0, yp_ff, xp_ff, idx_ff, val_ff};
   assign rsp_tuser  = sat_ff;
   assign rsp_tlast  = last_ff;

endmodule

// ----- hw/rtl/bivariate_monomial_expander.sv -----
// Top level of the bivariate monomial expander: controller plus datapath.
//
//  Channel  Dir  Signals                         Content
//  req      in   tvalid/tready/tdata[31:0]       one point (x, y), Q4.12
//  rsp      out  tvalid/tready/tdata/tuser/tlast  one monomial term per transfer
//  csr      in   wr_en/wr_data[2:0]               degree register, write only
//
// One point yields (d+1)(d+2)/2 terms, d = min(degree, 6). Term 0 is the constant step;
// every later term takes a multiply step, then a round/saturate/write-back step,
// through the single shared 32x16 multiplier. A new point is taken only in the idle
// state, after the last term of the previous point. Reset clears control state and
// sets degree to 2. A stalled rsp holds the sequencer in its constant or round step;
// no term is lost.
module bivariate_monomial_expander
   import bme_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [31:0]      req_tdata,   // [15:0] x_value, [31:16] y_value
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [47:0]      rsp_tdata,   // [31:0] term_value, [36:32] term_index,
                                         // [39:37] x_power, [42:40] y_power, zero fill
   output logic             rsp_tuser,   // [0] saturated
   output logic             rsp_tlast,
   input  logic             csr_wr_en,
   input  logic [DEG_W-1:0] csr_wr_data
);

   cmd_type    cmd;
   status_type status;

   bme_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .status      (status),
      .cmd         (cmd)
   );

   bme_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- hw/rtl/bme_checker.sv -----
// Port-level checks for the monomial expander, bound to the top level.
module bme_checker
   import bme_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [47:0]      rsp_tdata,
   input logic             rsp_tuser,
   input logic             rsp_tlast
);

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp payload changed while stalled");

   // After a point is taken the block is busy expanding it
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second point taken during expansion");

   // Term 0 is always 1.0 and unclipped
   a_first: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[36:32] == 5'd0) |-> (rsp_tdata[31:0] == ONE_Q24) && !rsp_tuser)
      else $error("first term is not 1.0");

   // Total power never exceeds the top degree
   a_power: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ({1'b0, rsp_tdata[39:37]} + {1'b0, rsp_tdata[42:40]}) <= 4'(MAX_DEGREE))
      else $error("term degree out of range");

   // No result right after reset
   a_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule

bind bivariate_monomial_expander bme_checker u_bme_checker (.*);
